// ===== design/brainfuck_instruction_executor_macros.svh =====
// ----------------------------------------------------------------------------
// Brainfuck instruction executor assertion macros
// Concurrent assertion wrappers on the i_clk domain.
// ----------------------------------------------------------------------------
`ifndef BRAINFUCK_INSTRUCTION_EXECUTOR_MACROS_SVH
`define BRAINFUCK_INSTRUCTION_EXECUTOR_MACROS_SVH

// Checked outside reset only.
`define BFIE_ASSERT(lbl, prop, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) prop) else $error(msg);

// Checked during reset as well.
`define BFIE_ASSERT_ALWAYS(lbl, prop, msg) \
    lbl: assert property (@(posedge i_clk) prop) else $error(msg);

`endif

// ===== design/bfie_pkg.sv =====
// ----------------------------------------------------------------------------
// Brainfuck instruction executor package
// Payload types, instruction kinds and error codes.
// ----------------------------------------------------------------------------
package bfie_pkg;

    typedef logic [2:0]  t_kind;
    typedef logic [15:0] t_pos;
    typedef logic [16:0] t_npos;
    typedef logic [31:0] t_word;
    typedef logic [1:0]  t_err;
    typedef logic [15:0] t_skip;

    localparam t_kind KIND_INC   = 3'd0;
    localparam t_kind KIND_DEC   = 3'd1;
    localparam t_kind KIND_LEFT  = 3'd2;
    localparam t_kind KIND_RIGHT = 3'd3;
    localparam t_kind KIND_READ  = 3'd4;
    localparam t_kind KIND_WRITE = 3'd5;
    localparam t_kind KIND_OPEN  = 3'd6;
    localparam t_kind KIND_CLOSE = 3'd7;

    localparam t_err ERR_NONE      = 2'd0;
    localparam t_err ERR_OVERFLOW  = 2'd1;
    localparam t_err ERR_UNDERFLOW = 2'd2;

    localparam t_npos PROG_SIZE = 17'd65536;
    localparam t_skip SKIP_MAX  = 16'hFFFF;

endpackage

// ===== design/bfie_in_if.sv =====
// ----------------------------------------------------------------------------
// Instruction channel
// Valid/ready channel carrying one instruction per transaction.
// ----------------------------------------------------------------------------
interface bfie_in_if;
    import bfie_pkg::*;

    logic  valid;
    logic  ready;
    t_kind kind;
    t_pos  position;
    t_word in_value;

    modport source (output valid, output kind, output position, output in_value, input ready);
    modport sink   (input valid, input kind, input position, input in_value, output ready);
endinterface

// ===== design/bfie_out_if.sv =====
// ----------------------------------------------------------------------------
// Result channel
// Valid/ready channel carrying one result per transaction.
// ----------------------------------------------------------------------------
interface bfie_out_if;
    import bfie_pkg::*;

    logic  valid;
    logic  ready;
    t_npos next_position;
    logic  out_valid;
    t_word out_value;
    t_err  error;

    modport source (output valid, output next_position, output out_valid, output out_value,
                    output error, input ready);
    modport sink   (input valid, input next_position, input out_valid, input out_value,
                    input error, output ready);
endinterface

// ===== design/brainfuck_instruction_executor.sv =====
// ----------------------------------------------------------------------------
// Brainfuck instruction executor
// Executes one instruction per transaction against a RAM tape and a RAM loop
// stack. Takes one instruction per cycle unless the result is stalled; after a
// pointer move or a close bracket that pops the stack, input is held off while
// the registered read of the tape RAM (new current cell) or the stack RAM (new
// stack top) completes. After reset a clearing pass zeroes all TAPE_DEPTH
// tape cells, and no instruction is accepted until it ends. The result register
// lets an instruction enter in the cycle the previous result is taken.
// ----------------------------------------------------------------------------
module brainfuck_instruction_executor #(
    parameter int TAPE_DEPTH  = 1024,
    parameter int STACK_DEPTH = 64,
    parameter int CELL_WIDTH  = 32
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    bfie_in_if.sink           i_in,
    bfie_out_if.source        o_out
);
    import bfie_pkg::*;

    localparam int AW = $clog2(TAPE_DEPTH);
    localparam int SW = $clog2(STACK_DEPTH);
    localparam int CW = $clog2(STACK_DEPTH + 1);
    localparam logic [AW-1:0] TAPE_LAST  = AW'(TAPE_DEPTH - 1);
    localparam logic [CW-1:0] STACK_FULL = CW'(STACK_DEPTH);

    logic [AW-1:0]         r_dp, n_dp;
    logic [CELL_WIDTH-1:0] r_cell, n_cell;
    t_pos                  r_top, n_top;
    logic [CW-1:0]         r_cnt, n_cnt;
    t_skip                 r_skip, n_skip;
    logic                  r_clr;
    logic [AW-1:0]         r_clr_addr;
    logic                  r_fetch;
    logic                  r_pop;
    logic                  r_ov;
    t_npos                 r_next, n_next;
    logic                  r_outv, n_outv;
    t_word                 r_val;
    t_err                  r_err, n_err;

    logic                  w_ready;
    logic                  w_acc;
    logic                  w_move;
    logic                  w_pop;
    logic                  w_tape_wr;
    logic                  w_push;
    t_npos                 w_adv;
    t_npos                 w_jump;
    logic [CELL_WIDTH-1:0] w_tape_rdata;
    t_pos                  w_stk_rdata;

    assign w_ready = !r_clr && !r_fetch && !r_pop && (!r_ov || o_out.ready);
    assign w_acc   = i_in.valid && w_ready;
    assign w_adv   = ((17'(i_in.position) + 17'd1) > PROG_SIZE) ? PROG_SIZE
                   : (17'(i_in.position) + 17'd1);
    assign w_jump  = (17'(r_top) > PROG_SIZE) ? PROG_SIZE : 17'(r_top);

    always_comb begin
        n_dp      = r_dp;
        n_cell    = r_cell;
        n_cnt     = r_cnt;
        n_skip    = r_skip;
        n_top     = r_top;
        n_next    = w_adv;
        n_outv    = 1'b0;
        n_err     = ERR_NONE;
        w_move    = 1'b0;
        w_pop     = 1'b0;
        w_tape_wr = 1'b0;
        w_push    = 1'b0;
        if (r_skip != '0) begin
            if (i_in.kind == KIND_OPEN) begin
                if (r_skip != SKIP_MAX) begin
                    n_skip = r_skip + 16'd1;
                end
            end else if (i_in.kind == KIND_CLOSE) begin
                n_skip = r_skip - 16'd1;
            end
        end else begin
            case (i_in.kind)
                KIND_INC: begin
                    n_cell    = r_cell + CELL_WIDTH'(1);
                    w_tape_wr = 1'b1;
                end
                KIND_DEC: begin
                    n_cell    = r_cell - CELL_WIDTH'(1);
                    w_tape_wr = 1'b1;
                end
                KIND_LEFT: begin
                    n_dp   = (r_dp == '0) ? TAPE_LAST : r_dp - AW'(1);
                    w_move = 1'b1;
                end
                KIND_RIGHT: begin
                    n_dp   = (r_dp == TAPE_LAST) ? '0 : r_dp + AW'(1);
                    w_move = 1'b1;
                end
                KIND_READ: begin
                    n_cell    = i_in.in_value[CELL_WIDTH-1:0];
                    w_tape_wr = 1'b1;
                end
                KIND_WRITE: begin
                    n_outv = 1'b1;
                end
                KIND_OPEN: begin
                    if (r_cell == '0) begin
                        n_skip = 16'd1;
                    end else if (r_cnt >= STACK_FULL) begin
                        n_err = ERR_OVERFLOW;
                    end else begin
                        w_push = 1'b1;
                        n_cnt  = r_cnt + CW'(1);
                        n_top  = i_in.position;
                    end
                end
                KIND_CLOSE: begin
                    if (r_cnt == '0) begin
                        n_err = ERR_UNDERFLOW;
                    end else begin
                        n_cnt = r_cnt - CW'(1);
                        w_pop = 1'b1;
                        if (r_cell != '0) begin
                            n_next = w_jump;
                        end
                    end
                end
                default: begin
                    n_err = ERR_NONE;
                end
            endcase
        end
    end

    bfie_ram #(
        .WIDTH (CELL_WIDTH),
        .DEPTH (TAPE_DEPTH)
    ) u_tape (
        .i_clk   (i_clk),
        .i_we    (r_clr || (w_acc && w_tape_wr)),
        .i_waddr (r_clr ? r_clr_addr : r_dp),
        .i_wdata (r_clr ? '0 : n_cell),
        .i_re    (w_acc && w_move),
        .i_raddr (n_dp),
        .o_rdata (w_tape_rdata)
    );

    bfie_ram #(
        .WIDTH (16),
        .DEPTH (STACK_DEPTH)
    ) u_stack (
        .i_clk   (i_clk),
        .i_we    (w_acc && w_push),
        .i_waddr (r_cnt[SW-1:0]),
        .i_wdata (i_in.position),
        .i_re    (w_acc && w_pop),
        .i_raddr (SW'(r_cnt - CW'(2))),
        .o_rdata (w_stk_rdata)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_dp       <= '0;
            r_cell     <= '0;
            r_cnt      <= '0;
            r_skip     <= '0;
            r_clr      <= 1'b1;
            r_clr_addr <= '0;
            r_fetch    <= 1'b0;
            r_pop      <= 1'b0;
            r_ov       <= 1'b0;
        end else begin
            if (r_clr) begin
                r_clr_addr <= r_clr_addr + AW'(1);
                if (r_clr_addr == TAPE_LAST) begin
                    r_clr <= 1'b0;
                end
            end
            r_fetch <= w_acc && w_move;
            r_pop   <= w_acc && w_pop;
            if (w_acc) begin
                r_dp   <= n_dp;
                r_cell <= n_cell;
                r_cnt  <= n_cnt;
                r_skip <= n_skip;
            end else if (r_fetch) begin
                r_cell <= w_tape_rdata;
            end
            if (r_fetch) begin
                r_ov <= 1'b1;
            end else if (w_acc) begin
                r_ov <= !w_move;
            end else if (o_out.ready) begin
                r_ov <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_acc) begin
            r_top  <= n_top;
            r_next <= n_next;
            r_outv <= n_outv;
            r_err  <= n_err;
            r_val  <= 32'(n_cell);
        end else begin
            if (r_pop) begin
                r_top <= w_stk_rdata;
            end
            if (r_fetch) begin
                r_val <= 32'(w_tape_rdata);
            end
        end
    end

    assign i_in.ready          = w_ready;
    assign o_out.valid         = r_ov;
    assign o_out.next_position = r_next;
    assign o_out.out_valid     = r_outv;
    assign o_out.out_value     = r_val;
    assign o_out.error         = r_err;
endmodule

// ===== design/bfie_ram.sv =====
// ----------------------------------------------------------------------------
// Generic RAM
// One write port, one read port, registered read data.
// ----------------------------------------------------------------------------
module bfie_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 1024
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;
endmodule

// ===== design/bfie_checker.sv =====
// ----------------------------------------------------------------------------
// Brainfuck instruction executor checker
// Port-level assertions, bound to the top level.
// ----------------------------------------------------------------------------
`include "brainfuck_instruction_executor_macros.svh"

module bfie_checker (
    input logic                 i_clk,
    input logic                 i_rst_n,
    input logic                 i_in_valid,
    input logic                 i_in_ready,
    input logic                 i_out_valid,
    input logic                 i_out_ready,
    input bfie_pkg::t_npos      i_next_position,
    input logic                 i_out_strobe,
    input bfie_pkg::t_word      i_out_value,
    input bfie_pkg::t_err       i_error
);
    import bfie_pkg::*;

    `BFIE_ASSERT_ALWAYS(a_clear_after_reset, !i_rst_n |=> !i_in_ready, "instruction taken during tape clear")
    `BFIE_ASSERT(a_no_accept_when_full, i_out_valid && !i_out_ready |-> !i_in_ready, "instruction taken while result stalled")
    `BFIE_ASSERT(a_error_no_strobe, i_out_valid && (i_error != ERR_NONE) |-> !i_out_strobe, "output strobe with error")
    `BFIE_ASSERT(a_hold_result, i_out_valid && !i_out_ready |=> i_out_valid && $stable(i_next_position) && $stable(i_out_value), "stalled result changed")
endmodule

bind brainfuck_instruction_executor bfie_checker u_bfie_checker (
    .i_clk           (i_clk),
    .i_rst_n         (i_rst_n),
    .i_in_valid      (i_in.valid),
    .i_in_ready      (i_in.ready),
    .i_out_valid     (o_out.valid),
    .i_out_ready     (o_out.ready),
    .i_next_position (o_out.next_position),
    .i_out_strobe    (o_out.out_valid),
    .i_out_value     (o_out.out_value),
    .i_error         (o_out.error)
);
